[design/gripper_admittance_impedance_loop_top_assert.svh]
// Assertion macros for the gripper admittance/impedance loop
`ifndef GRIPPER_ADMITTANCE_IMPEDANCE_LOOP_TOP_ASSERT_SVH
`define GRIPPER_ADMITTANCE_IMPEDANCE_LOOP_TOP_ASSERT_SVH

// same-cycle implication
`define GAIL_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gail assertion failed");

// next-cycle implication
`define GAIL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gail assertion failed");

`endif

[design/gail_pkg.sv]
// ----------------------------------------------------------------------------
// gail_pkg
// Shared types, codes and helpers of the gripper admittance/impedance loop.
// ----------------------------------------------------------------------------
package gail_pkg;

   localparam int W = 32;

   typedef logic signed [W-1:0] q_type;
   typedef logic [2:0]          func_type;
   typedef logic [2:0]          csr_index_type;

   localparam func_type FUNC_MEAS    = 3'd0;
   localparam func_type FUNC_TICK    = 3'd1;
   localparam func_type FUNC_GRIP    = 3'd2;
   localparam func_type FUNC_RELEASE = 3'd3;

   localparam csr_index_type REG_K_ADM  = 3'd0;
   localparam csr_index_type REG_B_ADM  = 3'd1;
   localparam csr_index_type REG_IM_ADM = 3'd2;
   localparam csr_index_type REG_K_IMP  = 3'd3;
   localparam csr_index_type REG_B_IMP  = 3'd4;
   localparam csr_index_type REG_IM_IMP = 3'd5;
   localparam csr_index_type REG_DT     = 3'd6;
   localparam csr_index_type REG_THR    = 3'd7;

   localparam q_type       TARGET_OPEN   = 32'sd671089;
   localparam q_type       TARGET_CLOSED = 32'sd0;
   localparam logic [63:0] GOAL_LIMIT    = 64'd281474976710;
   localparam logic [30:0] DT_RESET      = 31'd335544;
   localparam q_type       THR_RESET     = -32'sd5033165;

   localparam logic       KIND_GOAL  = 1'b0;
   localparam logic       KIND_REPLY = 1'b1;

   typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_POST, ST_OUT} state_type;

   typedef enum logic [2:0] {
      PH_D, PH_KD, PH_BV, PH_IM, PH_DTV, PH_DTP, PH_SQ
   } phase_type;

   function automatic logic signed [65:0] sx66(input q_type x);
      return {{34{x[31]}}, x};
   endfunction

   function automatic logic signed [65:0] wx66(input logic signed [63:0] x);
      return {{2{x[63]}}, x};
   endfunction

   function automatic q_type sat66(input logic signed [65:0] x);
      if (x > 66'sd2147483647) return 32'sh7FFF_FFFF;
      else if (x < -66'sd2147483648) return 32'sh8000_0000;
      else return x[31:0];
   endfunction

   function automatic logic [31:0] mag(input q_type x);
      logic [31:0] u;
      u = x;
      return x[31] ? (~u + 32'd1) : u;
   endfunction

endpackage

[design/gail_req_if.sv]
// ----------------------------------------------------------------------------
// gail_req_if
// Request channel: measurement, tick and command words.
// ----------------------------------------------------------------------------
interface gail_req_if;
   import gail_pkg::*;
   logic     valid;
   logic     ready;
   func_type func;
   q_type    meas_pos_left;
   q_type    meas_pos_right;
   q_type    meas_eff_left;
   q_type    meas_eff_right;

   modport source (output valid, func, meas_pos_left, meas_pos_right,
                   meas_eff_left, meas_eff_right, input ready);
   modport sink   (input valid, func, meas_pos_left, meas_pos_right,
                   meas_eff_left, meas_eff_right, output ready);
endinterface

[design/gail_rsp_if.sv]
// ----------------------------------------------------------------------------
// gail_rsp_if
// Response channel: goal words and command replies.
// ----------------------------------------------------------------------------
interface gail_rsp_if;
   import gail_pkg::*;
   logic  valid;
   logic  ready;
   logic  kind;
   q_type goal_pos_left;
   q_type goal_pos_right;
   q_type goal_vel_left;
   q_type goal_vel_right;
   logic  reply_ok;

   modport source (output valid, kind, goal_pos_left, goal_pos_right,
                   goal_vel_left, goal_vel_right, reply_ok, input ready);
   modport sink   (input valid, kind, goal_pos_left, goal_pos_right,
                   goal_vel_left, goal_vel_right, reply_ok, output ready);
endinterface

[design/gripper_admittance_impedance_loop_top.sv]
// Measurements are registered on accept; a grip/release/unknown reply word is valid
// in the cycle after. A tick runs both fingers; goal word only if q > GOAL_LIMIT.
// Throughput set by the single bit-serial 32x32 multiplier, one bit per cycle.
// Measurements and ticks are taken while a response word still waits.
// Reset (synchronous, active high): gains 0, time step 0.02, threshold -0.3,
// admittance mode, target open, velocities and held measurements zero.
// ----------------------------------------------------------------------------
// gripper_admittance_impedance_loop_top
// Two-finger admittance/impedance controller with a shared serial multiplier.
// ----------------------------------------------------------------------------
module gripper_admittance_impedance_loop_top (
   input  logic                     clock,
   input  logic                     reset,
   gail_req_if.sink                 req_bus,
   gail_rsp_if.source               rsp_bus,
   input  logic                     csr_wr_en,
   input  gail_pkg::csr_index_type  csr_index,
   input  logic [31:0]              csr_wdata
);
   import gail_pkg::*;

   localparam logic [4:0] MUL_LAST = 5'(W - 1);

   // configuration
   logic [31:0] k_adm_ff, k_adm_in, b_adm_ff, b_adm_in, im_adm_ff, im_adm_in;
   logic [31:0] k_imp_ff, k_imp_in, b_imp_ff, b_imp_in, im_imp_ff, im_imp_in;
   logic [30:0] dt_ff, dt_in;
   q_type       thr_ff, thr_in;

   // controller state
   logic  imp_ff, imp_in, closing_ff, closing_in;
   q_type vel_l_ff, vel_l_in, vel_r_ff, vel_r_in;
   q_type pos_l_ff, pos_l_in, pos_r_ff, pos_r_in;
   q_type eff_l_ff, eff_l_in, eff_r_ff, eff_r_in;

   // sequencer
   state_type state_ff, state_in;
   phase_type ph_ff, ph_in;
   logic      fing_ff, fing_in;

   // serial multiplier: pp holds {partial, multiplier bits still to go}
   logic [31:0] mc_ff, mc_in;
   logic [63:0] pp_ff, pp_in;
   logic        neg_ff, neg_in;
   logic [4:0]  cnt_ff, cnt_in;

   // intermediates
   logic signed [65:0] acc_ff, acc_in;
   q_type              f_ff, f_in;
   logic [63:0]        q_ff, q_in;
   q_type              gp_l_ff, gp_l_in, gp_r_ff, gp_r_in;

   // response word register
   logic  rsp_v_ff, rsp_v_in, kind_ff, kind_in, ok_ff, ok_in;
   q_type o_pl_ff, o_pl_in, o_pr_ff, o_pr_in, o_vl_ff, o_vl_in, o_vr_ff, o_vr_in;

   logic               req_ready;
   logic               slot_free;
   logic [32:0]        mul_sum;
   logic signed [63:0] prod;
   logic signed [63:0] prod16, prod24;
   q_type              cur_pos, cur_eff, cur_vel;
   q_type              dif, fval, av, vn, gp, sv, tgt;
   logic [63:0]        qn;
   logic               launch;
   logic [31:0]        l_mc, l_mp;
   logic               l_neg;

   assign slot_free = !rsp_v_ff || rsp_bus.ready;
   assign req_ready = (state_ff == ST_IDLE) &&
                      (req_bus.func == FUNC_MEAS || req_bus.func == FUNC_TICK || slot_free);
   assign req_bus.ready = req_ready;

   assign cur_pos = fing_ff ? pos_r_ff : pos_l_ff;
   assign cur_eff = fing_ff ? eff_r_ff : eff_l_ff;
   assign cur_vel = fing_ff ? vel_r_ff : vel_l_ff;

   // signed product and its floored shifts
   assign prod    = neg_ff ? -$signed(pp_ff) : $signed(pp_ff);
   assign prod16  = prod >>> 16;
   assign prod24  = prod >>> 24;
   assign mul_sum = {1'b0, pp_ff[63:32]} + (pp_ff[0] ? {1'b0, mc_ff} : 33'd0);

   always_comb begin
      k_adm_in = k_adm_ff; b_adm_in = b_adm_ff; im_adm_in = im_adm_ff;
      k_imp_in = k_imp_ff; b_imp_in = b_imp_ff; im_imp_in = im_imp_ff;
      dt_in = dt_ff; thr_in = thr_ff;
      imp_in = imp_ff; closing_in = closing_ff;
      vel_l_in = vel_l_ff; vel_r_in = vel_r_ff;
      pos_l_in = pos_l_ff; pos_r_in = pos_r_ff;
      eff_l_in = eff_l_ff; eff_r_in = eff_r_ff;
      state_in = state_ff; ph_in = ph_ff; fing_in = fing_ff;
      mc_in = mc_ff; pp_in = pp_ff; neg_in = neg_ff; cnt_in = cnt_ff;
      acc_in = acc_ff; f_in = f_ff; q_in = q_ff; gp_l_in = gp_l_ff; gp_r_in = gp_r_ff;
      rsp_v_in = rsp_v_ff && !rsp_bus.ready;
      kind_in = kind_ff; ok_in = ok_ff;
      o_pl_in = o_pl_ff; o_pr_in = o_pr_ff; o_vl_in = o_vl_ff; o_vr_in = o_vr_ff;
      launch = 1'b0; l_mc = '0; l_mp = '0; l_neg = 1'b0;
      tgt  = closing_ff ? TARGET_CLOSED : TARGET_OPEN;
      dif  = sat66(sx66(cur_pos) - sx66(tgt));
      fval = sat66(acc_ff - wx66(prod16));
      av   = sat66(wx66(prod16));
      vn   = sat66(sx66(cur_vel) + wx66(prod24));
      gp   = sat66(sx66(cur_pos) + wx66(prod24));
      sv   = sat66(sx66(f_ff) + sx66(cur_eff));
      qn   = q_ff + pp_ff;

      if (csr_wr_en) begin
         unique case (csr_index)
            REG_K_ADM:  k_adm_in  = csr_wdata;
            REG_B_ADM:  b_adm_in  = csr_wdata;
            REG_IM_ADM: im_adm_in = csr_wdata;
            REG_K_IMP:  k_imp_in  = csr_wdata;
            REG_B_IMP:  b_imp_in  = csr_wdata;
            REG_IM_IMP: im_imp_in = csr_wdata;
            REG_DT:     dt_in     = csr_wdata[30:0];
            REG_THR:    thr_in    = csr_wdata;
            default:    ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid && req_ready) begin
               if (req_bus.func == FUNC_MEAS) begin
                  pos_l_in = req_bus.meas_pos_left;
                  pos_r_in = req_bus.meas_pos_right;
                  eff_l_in = req_bus.meas_eff_left;
                  eff_r_in = req_bus.meas_eff_right;
                  if (req_bus.meas_eff_left < thr_ff || req_bus.meas_eff_right < thr_ff)
                     imp_in = 1'b1;
               end else if (req_bus.func == FUNC_TICK) begin
                  state_in = ST_POST;
                  ph_in    = PH_D;
                  fing_in  = 1'b0;
                  q_in     = '0;
               end else begin
                  // command reply word
                  rsp_v_in = 1'b1;
                  kind_in  = KIND_REPLY;
                  o_pl_in = '0; o_pr_in = '0; o_vl_in = '0; o_vr_in = '0;
                  ok_in    = 1'b0;
                  if (req_bus.func == FUNC_GRIP || req_bus.func == FUNC_RELEASE) begin
                     closing_in = (req_bus.func == FUNC_GRIP);
                     imp_in     = 1'b0;
                     ok_in      = 1'b1;
                  end
               end
            end
         end
         ST_MUL: begin
            pp_in  = {mul_sum, pp_ff[31:1]};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == MUL_LAST) state_in = ST_POST;
         end
         ST_POST: begin
            unique case (ph_ff)
               PH_D: begin
                  launch = 1'b1; l_mc = imp_ff ? k_imp_ff : k_adm_ff;
                  l_mp = mag(dif); l_neg = dif[31]; ph_in = PH_KD;
               end
               PH_KD: begin
                  acc_in = -sx66(cur_eff) - wx66(prod16);
                  launch = 1'b1; l_mc = imp_ff ? b_imp_ff : b_adm_ff;
                  l_mp = mag(cur_vel); l_neg = cur_vel[31]; ph_in = PH_BV;
               end
               PH_BV: begin
                  f_in = fval;
                  launch = 1'b1; l_mc = imp_ff ? im_imp_ff : im_adm_ff;
                  l_mp = mag(fval); l_neg = fval[31]; ph_in = PH_IM;
               end
               PH_IM: begin
                  launch = 1'b1; l_mc = {1'b0, dt_ff};
                  l_mp = mag(av); l_neg = av[31]; ph_in = PH_DTV;
               end
               PH_DTV: begin
                  // new velocity is kept whether or not a goal goes out
                  if (fing_ff) vel_r_in = vn;
                  else         vel_l_in = vn;
                  launch = 1'b1; l_mc = {1'b0, dt_ff};
                  l_mp = mag(vn); l_neg = vn[31]; ph_in = PH_DTP;
               end
               PH_DTP: begin
                  if (fing_ff) gp_r_in = gp;
                  else         gp_l_in = gp;
                  launch = 1'b1; l_mc = mag(sv);
                  l_mp = mag(sv); l_neg = 1'b0; ph_in = PH_SQ;
               end
               PH_SQ: begin
                  q_in = qn;
                  if (!fing_ff) begin
                     fing_in = 1'b1;
                     ph_in   = PH_D;
                  end else begin
                     fing_in  = 1'b0;
                     state_in = (qn > GOAL_LIMIT) ? ST_OUT : ST_IDLE;
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_OUT: begin
            if (slot_free) begin
               rsp_v_in = 1'b1;
               kind_in  = KIND_GOAL;
               o_pl_in  = gp_l_ff;
               o_pr_in  = gp_r_ff;
               o_vl_in  = vel_l_ff;
               o_vr_in  = vel_r_ff;
               ok_in    = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (launch) begin
         mc_in    = l_mc;
         pp_in    = {32'd0, l_mp};
         neg_in   = l_neg;
         cnt_in   = '0;
         state_in = ST_MUL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_adm_ff <= '0; b_adm_ff <= '0; im_adm_ff <= '0;
         k_imp_ff <= '0; b_imp_ff <= '0; im_imp_ff <= '0;
         dt_ff <= DT_RESET; thr_ff <= THR_RESET;
         imp_ff <= 1'b0; closing_ff <= 1'b0;
         vel_l_ff <= '0; vel_r_ff <= '0;
         pos_l_ff <= '0; pos_r_ff <= '0;
         eff_l_ff <= '0; eff_r_ff <= '0;
         state_ff <= ST_IDLE; ph_ff <= PH_D; fing_ff <= 1'b0;
         cnt_ff <= '0; rsp_v_ff <= 1'b0;
      end else begin
         k_adm_ff <= k_adm_in; b_adm_ff <= b_adm_in; im_adm_ff <= im_adm_in;
         k_imp_ff <= k_imp_in; b_imp_ff <= b_imp_in; im_imp_ff <= im_imp_in;
         dt_ff <= dt_in; thr_ff <= thr_in;
         imp_ff <= imp_in; closing_ff <= closing_in;
         vel_l_ff <= vel_l_in; vel_r_ff <= vel_r_in;
         pos_l_ff <= pos_l_in; pos_r_ff <= pos_r_in;
         eff_l_ff <= eff_l_in; eff_r_ff <= eff_r_in;
         state_ff <= state_in; ph_ff <= ph_in; fing_ff <= fing_in;
         cnt_ff <= cnt_in; rsp_v_ff <= rsp_v_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mc_ff <= mc_in; pp_ff <= pp_in; neg_ff <= neg_in;
      acc_ff <= acc_in; f_ff <= f_in; q_ff <= q_in;
      gp_l_ff <= gp_l_in; gp_r_ff <= gp_r_in;
      kind_ff <= kind_in; ok_ff <= ok_in;
      o_pl_ff <= o_pl_in; o_pr_ff <= o_pr_in; o_vl_ff <= o_vl_in; o_vr_ff <= o_vr_in;
   end

   assign rsp_bus.valid          = rsp_v_ff;
   assign rsp_bus.kind           = kind_ff;
   assign rsp_bus.goal_pos_left  = o_pl_ff;
   assign rsp_bus.goal_pos_right = o_pr_ff;
   assign rsp_bus.goal_vel_left  = o_vl_ff;
   assign rsp_bus.goal_vel_right = o_vr_ff;
   assign rsp_bus.reply_ok       = ok_ff;

`include "gripper_admittance_impedance_loop_top_assert.svh"

   `GAIL_ASSERT_NOW(a_busy_no_take, clock, reset, state_ff != ST_IDLE, !req_bus.ready)
   `GAIL_ASSERT_NEXT(a_mul_runs, clock, reset, state_ff == ST_MUL && cnt_ff != MUL_LAST, state_ff == ST_MUL)
   `GAIL_ASSERT_NOW(a_goal_not_ok, clock, reset, rsp_v_ff && kind_ff == KIND_GOAL, !ok_ff)
   `GAIL_ASSERT_NOW(a_right_busy, clock, reset, fing_ff, state_ff == ST_MUL || state_ff == ST_POST)

endmodule
